// File: rtl/stpseq_pkg.sv
// shared types, constants and coil tables for the stepper angle sequencer
`timescale 1ns / 1ps

package stpseq_pkg;

   // field widths
   localparam int ANGLE_W   = 9;
   localparam int TARGET_W  = 10;
   localparam int STEP_W    = 16;
   localparam int COUNT_W   = 18;
   localparam int PHASE_W   = 3;
   localparam int PAT_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int FRAC_W    = 8;

   // divider sequencing: one quotient bit per iteration
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(COUNT_W - 1);

   // angle and register constants
   localparam logic [TARGET_W-1:0] ANGLE_WRAP = TARGET_W'(360);
   localparam logic [STEP_W-1:0]   STEP_RESET = STEP_W'(461);

   // item kinds
   localparam logic MODE_COMMAND = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_ANGLE  = 2'd0,
      CSR_HALF_STEP   = 2'd1,
      CSR_START_ANGLE = 2'd2
   } csr_index_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESULT
   } seq_state_type;

   // divider request and response
   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] dividend;
      logic [STEP_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] quotient;
   } div_rsp_type;

   // full-step coil table
   function automatic logic [PAT_W-1:0] full_pattern(input logic [1:0] idx);
      logic [PAT_W-1:0] pat;
      case (idx)
         2'd0:    pat = 4'd1;
         2'd1:    pat = 4'd2;
         2'd2:    pat = 4'd4;
         default: pat = 4'd8;
      endcase
      return pat;
   endfunction

   // half-step coil table
   function automatic logic [PAT_W-1:0] half_pattern(input logic [PHASE_W-1:0] idx);
      logic [PAT_W-1:0] pat;
      case (idx)
         3'd0:    pat = 4'd9;
         3'd1:    pat = 4'd1;
         3'd2:    pat = 4'd3;
         3'd3:    pat = 4'd2;
         3'd4:    pat = 4'd6;
         3'd5:    pat = 4'd4;
         3'd6:    pat = 4'd12;
         default: pat = 4'd8;
      endcase
      return pat;
   endfunction

endpackage

// File: rtl/stpseq_divider.sv
// iterative restoring divider, one quotient bit per cycle through one subtractor
`timescale 1ns / 1ps

module stpseq_divider import stpseq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [STEP_W-1:0]    rem_ff, rem_in;
   logic [COUNT_W-1:0]   quot_ff, quot_in;
   logic [STEP_W-1:0]    divisor_ff, divisor_in;

   logic [STEP_W+1:0]    diff;
   logic                 fits;

   // shared trial subtract
   always_comb begin
      diff = {1'b0, rem_ff, quot_ff[COUNT_W-1]} - {2'b00, divisor_ff};
      fits = ~diff[STEP_W+1];
   end

   // iteration control
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quot_in    = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[STEP_W-1:0] : {rem_ff[STEP_W-2:0], quot_ff[COUNT_W-1]};
         quot_in = {quot_ff[COUNT_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// File: rtl/stepper_angle_sequencer.sv
// stepper angle sequencer top level: command sequencer, coil stepping, result register
// a tick or a rejected command gives its result beat in the cycle after acceptance
// an accepted command gets its result beat after the iterations of the shared
// restoring divider, one per quotient bit, plus hand-off; req_stall stays high meanwhile
// one item in flight at a time; a held result beat blocks the next accept until it leaves
// reset (synchronous, active high) clears the move and loads the default registers
`timescale 1ns / 1ps

module stepper_angle_sequencer import stpseq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // command and tick beats
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [TARGET_W-1:0]  req_target_angle,
   // result beats
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PAT_W-1:0]     rsp_coil_pattern,
   output logic                 rsp_accepted,
   output logic                 rsp_clockwise,
   output logic [COUNT_W-1:0]   rsp_patterns_left,
   output logic                 rsp_move_done,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   seq_state_type       state_ff, state_in;
   logic [STEP_W-1:0]   step_angle_ff, step_angle_in;
   logic                half_step_ff, half_step_in;
   logic [ANGLE_W-1:0]  cur_angle_ff, cur_angle_in;
   logic [COUNT_W-1:0]  remaining_ff, remaining_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic                moving_cw_ff, moving_cw_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PAT_W-1:0]    rsp_pattern_ff, rsp_pattern_in;
   logic                rsp_accepted_ff, rsp_accepted_in;
   logic                rsp_cw_ff, rsp_cw_in;
   logic [COUNT_W-1:0]  rsp_left_ff, rsp_left_in;
   logic                rsp_done_ff, rsp_done_in;

   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic                div_start;

   logic                rsp_free;
   logic [TARGET_W-1:0] target_adj;
   logic                target_cw;
   logic [TARGET_W-1:0] delta;
   logic [PHASE_W-1:0]  phase_mask;
   logic [PHASE_W-1:0]  phase_cur;
   logic [PHASE_W-1:0]  tab_idx;
   logic [PAT_W-1:0]    tick_pattern;
   logic [COUNT_W-1:0]  move_count;

   // target fold, direction and distance
   always_comb begin
      target_adj = (req_target_angle > ANGLE_WRAP) ? req_target_angle - ANGLE_WRAP
                                                   : req_target_angle;
      target_cw  = target_adj > {1'b0, cur_angle_ff};
      delta      = target_cw ? target_adj - {1'b0, cur_angle_ff}
                             : {1'b0, cur_angle_ff} - target_adj;
   end

   // coil table lookup for the next tick
   always_comb begin
      phase_mask   = half_step_ff ? PHASE_W'(7) : PHASE_W'(3);
      phase_cur    = phase_ff & phase_mask;
      tab_idx      = moving_cw_ff ? phase_cur : phase_mask - phase_cur;
      tick_pattern = half_step_ff ? half_pattern(tab_idx) : full_pattern(tab_idx[1:0]);
   end

   // whole coil cycles times table length: clear the low quotient bits
   always_comb begin
      if (half_step_ff) begin
         move_count = {div_rsp.quotient[COUNT_W-1:3], 3'b000};
      end else begin
         move_count = {div_rsp.quotient[COUNT_W-1:2], 2'b00};
      end
   end

   // divider request: step angle of zero counts as one
   always_comb begin
      div_req.start    = div_start;
      div_req.dividend = {delta[COUNT_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      div_req.divisor  = (step_angle_ff == '0) ? STEP_W'(1) : step_angle_ff;
   end

   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   // sequencer next state and outputs
   always_comb begin
      state_in        = state_ff;
      step_angle_in   = step_angle_ff;
      half_step_in    = half_step_ff;
      cur_angle_in    = cur_angle_ff;
      remaining_in    = remaining_ff;
      phase_in        = phase_ff;
      moving_cw_in    = moving_cw_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_pattern_in  = rsp_pattern_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_cw_in       = rsp_cw_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_done_in     = rsp_done_ff;
      div_start       = 1'b0;
      req_stall       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = ~rsp_free;
            if (req_valid && rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_pattern_in  = '0;
               rsp_accepted_in = 1'b0;
               if (req_mode == MODE_COMMAND) begin
                  if (remaining_ff == '0) begin
                     // start a move: result beat waits for the divider
                     moving_cw_in  = target_cw;
                     phase_in      = '0;
                     cur_angle_in  = target_adj[ANGLE_W-1:0];
                     div_start     = 1'b1;
                     rsp_valid_in  = 1'b0;
                     state_in      = ST_DIVIDE;
                  end
               end else if (remaining_ff != '0) begin
                  // step one pattern along the table
                  rsp_pattern_in = tick_pattern;
                  phase_in       = (phase_cur + 1'b1) & phase_mask;
                  remaining_in   = remaining_ff - 1'b1;
               end
               rsp_cw_in   = moving_cw_in;
               rsp_left_in = remaining_in;
               rsp_done_in = (remaining_in == '0);
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               remaining_in    = move_count;
               rsp_valid_in    = 1'b1;
               rsp_pattern_in  = '0;
               rsp_accepted_in = 1'b1;
               rsp_cw_in       = moving_cw_ff;
               rsp_left_in     = move_count;
               rsp_done_in     = (move_count == '0);
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_ANGLE:  step_angle_in = csr_data[STEP_W-1:0];
            CSR_HALF_STEP:   half_step_in  = csr_data[0];
            CSR_START_ANGLE: cur_angle_in  = csr_data[ANGLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_angle_ff <= STEP_RESET;
         half_step_ff  <= 1'b0;
         cur_angle_ff  <= '0;
         remaining_ff  <= '0;
         phase_ff      <= '0;
         moving_cw_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_angle_ff <= step_angle_in;
         half_step_ff  <= half_step_in;
         cur_angle_ff  <= cur_angle_in;
         remaining_ff  <= remaining_in;
         phase_ff      <= phase_in;
         moving_cw_ff  <= moving_cw_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_pattern_ff  <= rsp_pattern_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_cw_ff       <= rsp_cw_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_done_ff     <= rsp_done_in;
   end

   stpseq_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_coil_pattern  = rsp_pattern_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_clockwise     = rsp_cw_ff;
   assign rsp_patterns_left = rsp_left_ff;
   assign rsp_move_done     = rsp_done_ff;

`ifndef SYNTHESIS
   // no new beat while a command is being worked
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while a command is in progress");

   // a taken command never drives the coils
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_coil_pattern == '0))
      else $error("accepted command with nonzero coil pattern");

   // done flag agrees with the pattern count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_move_done == (rsp_patterns_left == '0)))
      else $error("move_done disagrees with patterns_left");

   // a tick during a move uses exactly one pattern
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode == MODE_TICK && remaining_ff != '0)
      |=> (remaining_ff == $past(remaining_ff) - 1'b1))
      else $error("tick did not consume one pattern");

   // the divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside a divide");
`endif

endmodule
